[hw/rtl/aesd_pkg.sv]
// Package for the escape stream decoder: byte codes, parser modes, queue packet
// type and the color/SGR helper functions. No dependencies.
`default_nettype none

package aesd_pkg;

  // Default depth of the queue between front and back
  localparam int AESD_QUEUE_DEPTH = 4;

  // Byte codes
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
  localparam logic [7:0] CH_RPAREN = 8'h29;  // )
  localparam logic [7:0] CH_QMARK  = 8'h3F;  // ?
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_FOUR   = 8'h34;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_UP_H   = 8'h48;  // H
  localparam logic [7:0] CH_LO_H   = 8'h68;  // h
  localparam logic [7:0] CH_LO_L   = 8'h6C;  // l
  localparam logic [7:0] CH_LO_M   = 8'h6D;  // m

  // SGR codes
  localparam logic [7:0] SGR_RESET  = 8'd0;
  localparam logic [7:0] SGR_BRIGHT = 8'd1;
  localparam logic [7:0] SGR_NORMAL = 8'd22;
  localparam logic [7:0] SGR_FG_LO  = 8'd30;
  localparam logic [7:0] SGR_FG_HI  = 8'd37;
  localparam logic [7:0] SGR_BG_LO  = 8'd40;
  localparam logic [7:0] SGR_BG_HI  = 8'd47;

  // Attribute after reset: white on black, normal intensity
  localparam logic [6:0] ATTR_DEFAULT = 7'h07;

  localparam logic [15:0] PARAM_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    MODE_GROUND,
    MODE_ESC,
    MODE_CSI_START,
    MODE_CSI_PARAM,
    MODE_Q1,
    MODE_Q4,
    MODE_Q47,
    MODE_P1,
    MODE_P2,
    MODE_P3
  } mode_t;

  typedef enum logic [1:0] {
    ACT_TEXT   = 2'd0,
    ACT_CURSOR = 2'd1,
    ACT_ATTR   = 2'd2
  } action_t;

  // Bytes released as text when a partial match breaks off
  typedef enum logic [2:0] {
    PFX_NONE,
    PFX_Q,      // ?
    PFX_Q4,     // ? 4
    PFX_Q47,    // ? 4 7
    PFX_ZERO    // 0
  } prefix_t;

  // One queue entry: released prefix text, then an optional main result
  typedef struct packed {
    prefix_t     prefix;
    logic        has_main;
    action_t     action;
    logic [7:0]  text_byte;
    logic [15:0] cursor_row;
    logic [15:0] cursor_col;
    logic [6:0]  attribute;
  } pkt_t;

  function automatic logic [2:0] swap_color(input logic [2:0] c);
    logic [2:0] r;
    case (c)
      3'd0:    r = 3'd0;
      3'd1:    r = 3'd4;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd6;
      3'd4:    r = 3'd1;
      3'd5:    r = 3'd5;
      3'd6:    r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  // Apply one SGR code to an attribute {back, bright, fore}
  function automatic logic [6:0] sgr_apply(input logic [6:0] t, input logic [7:0] code);
    logic [2:0] f;
    logic       b;
    logic [2:0] k;
    logic [7:0] off;
    f = t[2:0];
    b = t[3];
    k = t[6:4];
    off = 8'd0;
    if (code == SGR_RESET) begin
      f = 3'd7;
      b = 1'b0;
      k = 3'd0;
    end else if (code == SGR_BRIGHT) begin
      b = 1'b1;
    end else if (code == SGR_NORMAL) begin
      b = 1'b0;
    end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      off = code - SGR_FG_LO;
      f = swap_color(off[2:0]);
    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      off = code - SGR_BG_LO;
      k = swap_color(off[2:0]);
    end
    return {k, b, f};
  endfunction

  function automatic logic [1:0] pfx_count(input prefix_t p);
    logic [1:0] n;
    case (p)
      PFX_Q:    n = 2'd1;
      PFX_Q4:   n = 2'd2;
      PFX_Q47:  n = 2'd3;
      PFX_ZERO: n = 2'd1;
      default:  n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] pfx_byte(input prefix_t p, input logic [1:0] i);
    logic [7:0] r;
    case (p)
      PFX_Q, PFX_Q4, PFX_Q47: begin
        case (i)
          2'd0:    r = CH_QMARK;
          2'd1:    r = CH_FOUR;
          default: r = CH_SEVEN;
        endcase
      end
      PFX_ZERO: r = CH_ZERO;
      default:  r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ansi_escape_stream_decoder.sv]
// Terminal escape stream decoder. Takes one byte of terminal output per request and
// yields text bytes, cursor moves (CSI ... H, zero-based) and color attributes
// (CSI ... m, attribute = fore | bright<<3 | back<<4); fixed mode sequences are
// swallowed and other escapes dropped. A byte is accepted every cycle while the
// internal queue has room. The back end sends one result per cycle while the
// receiver does not stall, so a byte that breaks off a partial sequence and
// releases held bytes (up to four results) keeps it busy for all of them, and the
// queue of QUEUE_DEPTH packets absorbs such bursts. A result is written into the
// queue and then loaded into the output register before it can be taken; out_last
// marks the final result of each byte, and bytes that produce no result emit
// nothing. Depends on aesd_pkg, aesd_front, aesd_queue and aesd_back.
`default_nettype none

module ansi_escape_stream_decoder
  import aesd_pkg::*;
#(
  parameter int QUEUE_DEPTH = AESD_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_byte,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_action,
  output logic [7:0]       out_text_byte,
  output logic [15:0]      out_cursor_row,
  output logic [15:0]      out_cursor_col,
  output logic [6:0]       out_attribute,
  output logic             out_last
);

  pkt_t q_wr_data;
  pkt_t q_head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_not_empty;

  // Parser
  aesd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  // Packet queue
  aesd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   (q_wr_data),
    .pop       (q_pop),
    .rd_data   (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Result expansion and output register
  aesd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .head_valid     (q_not_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_text_byte  (out_text_byte),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_attribute  (out_attribute),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

[hw/rtl/aesd_front.sv]
// Front end of the escape decoder: parser state machine, one byte per cycle while the queue has room.
// Turns each byte into a queue packet. Depends on aesd_pkg.
`default_nettype none

module aesd_front
  import aesd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  output logic            in_stall,
  input  wire logic       q_full,
  output logic            q_push,
  output pkt_t            q_data
);

  mode_t       mode_r, mode_nxt;
  logic [15:0] pv_r, pv_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [15:0] first_r, first_nxt;
  logic [15:0] second_r, second_nxt;
  logic [6:0]  trial_r, trial_nxt;
  logic [6:0]  attr_r, attr_nxt;

  logic        accept;
  logic        gnd_c;     // handle byte as in ground mode
  logic        esc_c;     // handle byte as the one after ESC
  logic        is_digit;
  logic [19:0] acc;
  logic [15:0] f0, f1;
  logic [6:0]  sgr_t;
  pkt_t        pkt;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_digit = in_byte inside {[CH_ZERO:CH_NINE]};

  // Decimal accumulate with saturation: pv*10 + digit
  assign acc = {1'b0, pv_r, 3'b000} + {3'b000, pv_r, 1'b0} + {12'd0, in_byte - CH_ZERO};

  // SGR applied to the field that ends here
  assign sgr_t = sgr_apply(trial_r, pv_r[7:0]);

  // Cursor fields as seen at the final byte
  always_comb begin
    f0 = (idx_r == 2'd0) ? pv_r : first_r;
    if (idx_r == 2'd0) begin
      f1 = 16'd0;
    end else if (idx_r == 2'd1) begin
      f1 = pv_r;
    end else begin
      f1 = second_r;
    end
  end

  // Next state and packet
  always_comb begin
    mode_nxt   = mode_r;
    pv_nxt     = pv_r;
    idx_nxt    = idx_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    trial_nxt  = trial_r;
    attr_nxt   = attr_r;
    gnd_c      = 1'b0;
    esc_c      = 1'b0;
    pkt        = '0;
    pkt.prefix = PFX_NONE;
    pkt.action = ACT_TEXT;

    case (mode_r)
      MODE_GROUND: gnd_c = 1'b1;
      MODE_ESC:    esc_c = 1'b1;
      MODE_CSI_START, MODE_CSI_PARAM: begin
        if (is_digit) begin
          mode_nxt = MODE_CSI_PARAM;
          pv_nxt   = (acc > {4'd0, PARAM_MAX}) ? PARAM_MAX : acc[15:0];
        end else if (in_byte == CH_SEMI) begin
          // end of a field
          mode_nxt  = MODE_CSI_PARAM;
          trial_nxt = sgr_t;
          if (idx_r == 2'd0) first_nxt = pv_r;
          if (idx_r == 2'd1) second_nxt = pv_r;
          if (idx_r != 2'd3) idx_nxt = idx_r + 2'd1;
          pv_nxt = 16'd0;
        end else if (mode_r == MODE_CSI_START) begin
          if (in_byte == CH_QMARK) begin
            mode_nxt = MODE_Q1;
          end else begin
            // ESC [ with no parameters: byte taken afresh
            gnd_c = 1'b1;
          end
        end else begin
          // final byte
          mode_nxt = MODE_GROUND;
          if (in_byte == CH_UP_H) begin
            pkt.has_main   = 1'b1;
            pkt.action     = ACT_CURSOR;
            pkt.cursor_row = (f0 == 16'd0) ? 16'd0 : f0 - 16'd1;
            pkt.cursor_col = (f1 == 16'd0) ? 16'd0 : f1 - 16'd1;
          end else if (in_byte == CH_LO_M) begin
            trial_nxt     = sgr_t;
            attr_nxt      = sgr_t;
            pkt.has_main  = 1'b1;
            pkt.action    = ACT_ATTR;
            pkt.attribute = sgr_t;
          end
        end
      end
      MODE_Q1: begin
        if (in_byte == CH_FOUR) begin
          mode_nxt = MODE_Q4;
        end else begin
          pkt.prefix = PFX_Q;
          gnd_c      = 1'b1;
        end
      end
      MODE_Q4: begin
        if (in_byte == CH_SEVEN) begin
          mode_nxt = MODE_Q47;
        end else begin
          pkt.prefix = PFX_Q4;
          gnd_c      = 1'b1;
        end
      end
      MODE_Q47: begin
        if (in_byte == CH_LO_H || in_byte == CH_LO_L) begin
          mode_nxt = MODE_GROUND;
        end else begin
          pkt.prefix = PFX_Q47;
          gnd_c      = 1'b1;
        end
      end
      MODE_P1: begin
        if (in_byte == CH_ZERO) begin
          mode_nxt = MODE_P2;
        end else begin
          gnd_c = 1'b1;
        end
      end
      MODE_P2: begin
        if (in_byte == CH_ESC) begin
          mode_nxt = MODE_P3;
        end else begin
          pkt.prefix = PFX_ZERO;
          gnd_c      = 1'b1;
        end
      end
      MODE_P3: begin
        if (in_byte == CH_SEVEN) begin
          mode_nxt = MODE_GROUND;
        end else begin
          // held '0' is text, held ESC restarts an escape with this byte
          pkt.prefix = PFX_ZERO;
          esc_c      = 1'b1;
        end
      end
      default: mode_nxt = MODE_GROUND;
    endcase

    // Byte in ground mode
    if (gnd_c) begin
      if (in_byte == CH_ESC) begin
        mode_nxt = MODE_ESC;
      end else begin
        mode_nxt      = MODE_GROUND;
        pkt.has_main  = 1'b1;
        pkt.action    = ACT_TEXT;
        pkt.text_byte = in_byte;
      end
    end

    // Byte after ESC
    if (esc_c) begin
      if (in_byte == CH_LBRACK) begin
        mode_nxt   = MODE_CSI_START;
        pv_nxt     = 16'd0;
        idx_nxt    = 2'd0;
        first_nxt  = 16'd0;
        second_nxt = 16'd0;
        trial_nxt  = attr_r;
      end else if (in_byte == CH_RPAREN) begin
        mode_nxt = MODE_P1;
      end else begin
        mode_nxt = MODE_GROUND;
      end
    end
  end

  assign q_data = pkt;
  assign q_push = accept && (pkt.has_main || pkt.prefix != PFX_NONE);

  // Parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_GROUND;
      pv_r     <= 16'd0;
      idx_r    <= 2'd0;
      first_r  <= 16'd0;
      second_r <= 16'd0;
      trial_r  <= ATTR_DEFAULT;
      attr_r   <= ATTR_DEFAULT;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pv_r     <= pv_nxt;
      idx_r    <= idx_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      trial_r  <= trial_nxt;
      attr_r   <= attr_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/aesd_queue.sv]
// Short packet queue between parser front and result back end.
// Register array with head read in place. Depends on aesd_pkg.
`default_nettype none

module aesd_queue
  import aesd_pkg::*;
#(
  parameter int DEPTH = AESD_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire pkt_t wr_data,
  input  wire logic pop,
  output pkt_t      rd_data,
  output logic      full,
  output logic      not_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pkt_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/aesd_back.sv]
// Back end of the escape decoder: expands each queue packet into one to
// four results and drives the registered output channel. Depends on aesd_pkg.
`default_nettype none

module aesd_back
  import aesd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pkt_t        head,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_action,
  output logic [7:0]       out_text_byte,
  output logic [15:0]      out_cursor_row,
  output logic [15:0]      out_cursor_col,
  output logic [6:0]       out_attribute,
  output logic             out_last
);

  logic [1:0]  sub_r, sub_nxt;     // result index within the head packet
  logic        valid_r, valid_nxt;
  logic [1:0]  act_r, act_nxt;
  logic [7:0]  text_r, text_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] col_r, col_nxt;
  logic [6:0]  attr_r, attr_nxt;
  logic        last_r, last_nxt;

  logic [1:0]  n_pfx;
  logic        is_final;
  logic        load;

  assign n_pfx    = pfx_count(head.prefix);
  assign is_final = head.has_main ? (sub_r == n_pfx) : (sub_r == n_pfx - 2'd1);
  assign load     = head_valid && (!valid_r || !out_stall);
  assign pop      = load && is_final;

  // Select the current result of the head packet
  always_comb begin
    sub_nxt   = sub_r;
    valid_nxt = valid_r && out_stall;
    act_nxt   = act_r;
    text_nxt  = text_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    attr_nxt  = attr_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      last_nxt  = is_final;
      sub_nxt   = is_final ? 2'd0 : sub_r + 2'd1;
      if (sub_r < n_pfx) begin
        act_nxt  = ACT_TEXT;
        text_nxt = pfx_byte(head.prefix, sub_r);
        row_nxt  = 16'd0;
        col_nxt  = 16'd0;
        attr_nxt = 7'd0;
      end else begin
        act_nxt  = head.action;
        text_nxt = head.text_byte;
        row_nxt  = head.cursor_row;
        col_nxt  = head.cursor_col;
        attr_nxt = head.attribute;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      sub_r   <= sub_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload registers
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    text_r <= text_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    attr_r <= attr_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_action     = act_r;
  assign out_text_byte  = text_r;
  assign out_cursor_row = row_r;
  assign out_cursor_col = col_r;
  assign out_attribute  = attr_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

[tb/ansi_escape_stream_decoder_tb.sv]
// Testbench for ansi_escape_stream_decoder: a byte driver, a result monitor and a
// byte-level predictor of the escape parser and color state.
// Depends on aesd_pkg and the ansi_escape_stream_decoder RTL.
`timescale 1ns / 100ps

module ansi_escape_stream_decoder_tb;
  import aesd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 200;
  localparam int MAX_PER_BYTE = 4;

  // Extra characters used by the fixed sequences
  localparam logic [7:0] CH_TWO = 8'h32;
  localparam logic [7:0] CH_UP_J = 8'h4A;

  // Swapped color index for SGR 30-37 and 40-47, entry i at bits [3*i +: 3]
  localparam logic [23:0] COLOR_SWAP = {3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4, 3'd0};

  // Fixed sequences, first byte in the highest used byte, zero padding above
  localparam logic [47:0] SEQ_ALT_ON =
    {CH_ESC, CH_LBRACK, CH_QMARK, CH_FOUR, CH_SEVEN, CH_LO_H};
  localparam logic [47:0] SEQ_ALT_OFF =
    {CH_ESC, CH_LBRACK, CH_QMARK, CH_FOUR, CH_SEVEN, CH_LO_L};
  localparam logic [47:0] SEQ_CHARSET = {8'h00, CH_ESC, CH_RPAREN, CH_ZERO, CH_ESC, CH_SEVEN};
  localparam logic [47:0] SEQ_CLEAR = {16'h0000, CH_ESC, CH_LBRACK, CH_TWO, CH_UP_J};

  typedef struct packed {
    action_t     action;
    logic [7:0]  text_byte;
    logic [15:0] cursor_row;
    logic [15:0] cursor_col;
    logic [6:0]  attribute;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = 8'h00;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_action;
  logic [7:0]  out_text_byte;
  logic [15:0] out_cursor_row;
  logic [15:0] out_cursor_col;
  logic [6:0]  out_attribute;
  logic        out_last;

  ansi_escape_stream_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_byte        (in_byte),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_text_byte  (out_text_byte),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_attribute  (out_attribute),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  logic [7:0] pending_bytes[$];
  result_t    expected_results[$];
  bit         mismatch_seen = 1'b0;

  // Parser and color state of the predictor
  mode_t       parse_mode = MODE_GROUND;
  logic [15:0] param_acc = 16'd0;
  logic [1:0]  field_cnt = 2'd0;
  logic [15:0] first_param = 16'd0;
  logic [15:0] second_param = 16'd0;
  logic [7:0]  held_seq[0:2];
  logic [1:0]  held_len = 2'd0;
  logic        cur_bright = 1'b0;
  logic [2:0]  cur_fore = 3'd7;
  logic [2:0]  cur_back = 3'd0;
  logic [6:0]  trial_attr = ATTR_DEFAULT;
  logic [7:0]  replay_bytes[$];
  result_t     byte_results[0:MAX_PER_BYTE-1];
  int          byte_result_cnt;

  function automatic logic [6:0] sgr_update(input logic [6:0] attr_in, input logic [15:0] value);
    logic [7:0] code;
    logic [2:0] fg;
    logic [2:0] bg;
    logic       br;
    int         idx;
    code = value[7:0];
    fg = attr_in[2:0];
    br = attr_in[3];
    bg = attr_in[6:4];
    if (code == SGR_RESET) begin
      fg = 3'd7;
      br = 1'b0;
      bg = 3'd0;
    end else if (code == SGR_BRIGHT) begin
      br = 1'b1;
    end else if (code == SGR_NORMAL) begin
      br = 1'b0;
    end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
      idx = int'(code - SGR_FG_LO);
      fg = COLOR_SWAP[idx*3 +: 3];
    end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
      idx = int'(code - SGR_BG_LO);
      bg = COLOR_SWAP[idx*3 +: 3];
    end
    return {bg, br, fg};
  endfunction

  task automatic record_result(input action_t act, input logic [7:0] txt,
                               input logic [15:0] row, input logic [15:0] col,
                               input logic [6:0] attr);
    if (byte_result_cnt < MAX_PER_BYTE) begin
      byte_results[byte_result_cnt] = '{act, txt, row, col, attr, 1'b0};
      byte_result_cnt++;
    end
  endtask

  task automatic hold_byte(input logic [7:0] c, input mode_t next_mode);
    if (held_len < 2'd3) begin
      held_seq[held_len] = c;
      held_len++;
    end
    parse_mode = next_mode;
  endtask

  // Partial match broke off: replay held bytes and the breaking byte from ground
  task automatic break_off(input logic [7:0] c);
    int i;
    parse_mode = MODE_GROUND;
    replay_bytes.push_front(c);
    for (i = int'(held_len) - 1; i >= 0; i--) replay_bytes.push_front(held_seq[i]);
    held_len = 2'd0;
  endtask

  task automatic end_param_field();
    trial_attr = sgr_update(trial_attr, param_acc);
    if (field_cnt == 2'd0) first_param = param_acc;
    else if (field_cnt == 2'd1) second_param = param_acc;
    if (field_cnt < 2'd3) field_cnt++;
    param_acc = 16'd0;
  endtask

  // Expected results of one accepted request byte
  task automatic decode_byte(input logic [7:0] in_b);
    logic [7:0]  c;
    logic [15:0] row_f;
    logic [15:0] col_f;
    int unsigned acc;
    int          i;
    byte_result_cnt = 0;
    replay_bytes.push_back(in_b);
    while (replay_bytes.size() > 0) begin
      c = replay_bytes.pop_front();
      case (parse_mode)
        MODE_ESC: begin
          held_len = 2'd0;
          if (c == CH_LBRACK) begin
            parse_mode = MODE_CSI_START;
            param_acc = 16'd0;
            field_cnt = 2'd0;
            first_param = 16'd0;
            second_param = 16'd0;
            trial_attr = {cur_back, cur_bright, cur_fore};
          end else if (c == CH_RPAREN) begin
            parse_mode = MODE_P1;
          end else begin
            parse_mode = MODE_GROUND;
          end
        end
        MODE_CSI_START: begin
          if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SEMI) begin
            parse_mode = MODE_CSI_PARAM;
            replay_bytes.push_front(c);
          end else if (c == CH_QMARK) begin
            hold_byte(c, MODE_Q1);
          end else begin
            parse_mode = MODE_GROUND;
            replay_bytes.push_front(c);
          end
        end
        MODE_CSI_PARAM: begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            acc = 32'(param_acc) * 10 + 32'(c - CH_ZERO);
            param_acc = (acc > 32'(PARAM_MAX)) ? PARAM_MAX : acc[15:0];
          end else if (c == CH_SEMI) begin
            end_param_field();
          end else begin
            parse_mode = MODE_GROUND;
            if (c == CH_UP_H) begin
              row_f = (field_cnt == 2'd0) ? param_acc : first_param;
              col_f = (field_cnt == 2'd0) ? 16'd0 :
                      (field_cnt == 2'd1) ? param_acc : second_param;
              record_result(ACT_CURSOR, 8'd0, (row_f != 0) ? row_f - 16'd1 : 16'd0,
                            (col_f != 0) ? col_f - 16'd1 : 16'd0, 7'd0);
            end else if (c == CH_LO_M) begin
              trial_attr = sgr_update(trial_attr, param_acc);
              cur_fore = trial_attr[2:0];
              cur_bright = trial_attr[3];
              cur_back = trial_attr[6:4];
              record_result(ACT_ATTR, 8'd0, 16'd0, 16'd0, {cur_back, cur_bright, cur_fore});
            end
          end
        end
        MODE_Q1: if (c == CH_FOUR) hold_byte(c, MODE_Q4); else break_off(c);
        MODE_Q4: if (c == CH_SEVEN) hold_byte(c, MODE_Q47); else break_off(c);
        MODE_Q47: begin
          if (c == CH_LO_H || c == CH_LO_L) begin
            held_len = 2'd0;
            parse_mode = MODE_GROUND;
          end else begin
            break_off(c);
          end
        end
        MODE_P1: if (c == CH_ZERO) hold_byte(c, MODE_P2); else break_off(c);
        MODE_P2: if (c == CH_ESC) hold_byte(c, MODE_P3); else break_off(c);
        MODE_P3: begin
          if (c == CH_SEVEN) begin
            held_len = 2'd0;
            parse_mode = MODE_GROUND;
          end else begin
            break_off(c);
          end
        end
        default: begin
          parse_mode = MODE_GROUND;
          if (c == CH_ESC) begin
            held_len = 2'd0;
            parse_mode = MODE_ESC;
          end else begin
            record_result(ACT_TEXT, c, 16'd0, 16'd0, 7'd0);
          end
        end
      endcase
    end
    for (i = 0; i < byte_result_cnt; i++) begin
      if (i == byte_result_cnt - 1) byte_results[i].last = 1'b1;
      expected_results.push_back(byte_results[i]);
    end
  endtask

  // Stimulus builders
  task automatic add_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  task automatic add_esc(input string s);
    pending_bytes.push_back(CH_ESC);
    add_text(s);
  endtask

  task automatic add_number(input int unsigned v);
    logic [7:0]  digs[$];
    int unsigned r;
    r = v;
    do begin
      digs.push_front(CH_ZERO + 8'(r % 10));
      r = r / 10;
    end while (r != 0);
    while (digs.size() > 0) pending_bytes.push_back(digs.pop_front());
  endtask

  // Negative means an empty field
  task automatic add_field(input int v);
    if (v >= 0) begin
      if ($urandom_range(0, 7) == 0) add_byte(CH_ZERO);
      add_number(v);
    end
  endtask

  function automatic int rand_position();
    case ($urandom_range(0, 9))
      0:       return -1;
      1:       return $urandom_range(0, 99999);
      2:       return 0;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  function automatic int rand_sgr_code();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 22;
      3:       return 30 + $urandom_range(0, 7);
      4:       return 40 + $urandom_range(0, 7);
      5:       return $urandom_range(0, 300);
      6:       return 286 + $urandom_range(0, 17);
      default: return -1;
    endcase
  endfunction

  // Whole or broken fixed sequence; a broken one ends on a random byte
  task automatic add_fixed(input logic [47:0] seq, input int len);
    int n;
    int i;
    n = len;
    if ($urandom_range(0, 1) == 1) n = $urandom_range(2, len - 1);
    for (i = 0; i < n; i++) add_byte(seq[(len - 1 - i)*8 +: 8]);
    if (n < len) begin
      case ($urandom_range(0, 3))
        0:       add_byte(CH_ESC);
        1:       add_byte(CH_LBRACK);
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic add_random_sequence();
    int         n;
    int         i;
    int         pick;
    logic [7:0] fin;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
    end else if (pick < 40) begin
      add_esc("[");
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) begin
        if (i > 0) add_byte(CH_SEMI);
        add_field(rand_position());
      end
      add_byte(CH_UP_H);
    end else if (pick < 65) begin
      add_esc("[");
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) begin
        if (i > 0) add_byte(CH_SEMI);
        add_field(rand_sgr_code());
      end
      add_byte(CH_LO_M);
    end else if (pick < 78) begin
      case ($urandom_range(0, 3))
        0:       add_fixed(SEQ_ALT_ON, 6);
        1:       add_fixed(SEQ_ALT_OFF, 6);
        2:       add_fixed(SEQ_CHARSET, 5);
        default: add_fixed(SEQ_CLEAR, 4);
      endcase
    end else if (pick < 86) begin
      add_esc("[");
      add_field($urandom_range(0, 500));
      fin = 8'($urandom_range(0, 255));
      while ((fin >= CH_ZERO && fin <= CH_NINE) || fin == CH_SEMI) fin = 8'($urandom_range(0, 255));
      add_byte(fin);
    end else if (pick < 93) begin
      add_byte(CH_ESC);
      add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_esc("[");
      fin = 8'($urandom_range(0, 255));
      while ((fin >= CH_ZERO && fin <= CH_NINE) || fin == CH_SEMI) fin = 8'($urandom_range(0, 255));
      add_byte(fin);
    end
  endtask

  // Byte driver: bursts of random length separated by random gaps
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte <= 8'h00;
      gap_left = 0;
      burst_left = $urandom_range(1, 40);
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_byte);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = $urandom_range(1, 8);
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
        end
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls: short stall runs between free runs, with long free stretches
  int  stall_left = 0;
  bit  stalling = 1'b0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (stalling) begin
      stalling = 1'b0;
      stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
    end else begin
      stalling = 1'b1;
      stall_left = $urandom_range(1, 12);
    end
    out_stall <= stalling;
  end

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      mismatch_seen = 1'b1;
    end
  endtask

  // Result monitor
  result_t next_result;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request pending: action %0d", out_action);
        mismatch_seen = 1'b1;
      end else begin
        next_result = expected_results.pop_front();
        compare_field("out_action", 32'(next_result.action), 32'(out_action));
        compare_field("out_text_byte", 32'(next_result.text_byte), 32'(out_text_byte));
        compare_field("out_cursor_row", 32'(next_result.cursor_row), 32'(out_cursor_row));
        compare_field("out_cursor_col", 32'(next_result.cursor_col), 32'(out_cursor_col));
        compare_field("out_attribute", 32'(next_result.attribute), 32'(out_attribute));
        compare_field("out_last", 32'(next_result.last), 32'(out_last));
      end
    end
  end

  // Watchdog on cycles without any handshake
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  int directed_len;

  initial begin
    // Directed: field extremes, cursor and SGR corner cases, swallowed and broken sequences
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("Az~");
    add_esc("[5;10H");
    add_esc("[H");
    add_esc("[0;0H");
    add_esc("[;7H");
    add_esc("[3;4;9H");
    add_esc("[99999;70000H");
    add_esc("[1;31;44m");
    add_esc("[m");
    add_esc("[;m");
    add_esc("[286m");
    add_esc("[22;0;1;37;47;99m");
    add_esc("[2J");
    add_esc("[5x");
    add_esc(")0");
    add_esc("7");
    add_esc("[?47h");
    add_esc("[?47l");
    add_esc("[?4Z");
    add_esc("[?47");
    add_esc("[2H");
    add_esc("[?q");
    add_esc(")0");
    add_esc("[1m");
    add_esc(")X");
    add_esc(")0");
    add_esc("A");
    add_esc("x");
    add_byte(CH_ESC);
    add_byte(CH_ESC);
    add_esc("[12");
    add_esc("[H");
    add_esc("[?");
    add_esc("[7;300H");
    directed_len = pending_bytes.size();

    // Random: mostly well-formed sequences, some noise and broken ones
    while (pending_bytes.size() < directed_len + RANDOM_BYTES) add_random_sequence();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    #1;
    if (!mismatch_seen && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
